>>> hw/rtl/cm2a_pkg.sv
// Shared types, action codes and saturation helper for the complex 2x2 accumulator.
`timescale 1ns / 1ps

package cm2a_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int ACT_BITS  = 3;
  localparam int NUM_WORDS = 8;
  localparam int SUM_BITS  = 2 * WORD_BITS + 3;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [2*WORD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // action codes
  localparam logic [ACT_BITS-1:0] ACT_ZERO  = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_IDENT = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_LOAD  = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_ADD   = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_SUB   = 3'd4;
  localparam logic [ACT_BITS-1:0] ACT_SCALE = 3'd5;
  localparam logic [ACT_BITS-1:0] ACT_MUL   = 3'd6;

  // word positions of the diagonal real parts
  localparam logic [2:0] IDX_M00_RE = 3'd0;
  localparam logic [2:0] IDX_M11_RE = 3'd6;

  localparam word_t WORD_MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};
  // 1.0, clamped when it does not fit the word
  localparam word_t ONE_W = (FRAC_BITS >= WORD_BITS - 1) ? WORD_MAX_W
                                                         : (word_t'(1) << FRAC_BITS);
  localparam sum_t  HALF_S = sum_t'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [ACT_BITS-1:0] action;
    word_t b00_re;
    word_t b00_im;
    word_t b01_re;
    word_t b01_im;
    word_t b10_re;
    word_t b10_im;
    word_t b11_re;
    word_t b11_im;
    word_t scale_factor;
  } in_item_t;

  typedef struct packed {
    word_t m00_re;
    word_t m00_im;
    word_t m01_re;
    word_t m01_im;
    word_t m10_re;
    word_t m10_im;
    word_t m11_re;
    word_t m11_im;
  } out_item_t;

  // operands routed to one lane: accumulator row, operand column, own words
  typedef struct packed {
    logic [ACT_BITS-1:0] action;
    word_t a0r;
    word_t a0i;
    word_t a1r;
    word_t a1i;
    word_t x0r;
    word_t x0i;
    word_t x1r;
    word_t x1i;
    word_t own_acc;
    word_t own_b;
    word_t scale;
  } lane_in_t;

  function automatic word_t sat_word(input sum_t v);
    word_t r;
    if (v > sum_t'(WORD_MAX_W)) begin
      r = WORD_MAX_W;
    end else if (v < sum_t'(WORD_MIN_W)) begin
      r = WORD_MIN_W;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/cm2a_lane.sv
// One accumulator word lane: four-product dot term, round, saturate, action select.
`timescale 1ns / 1ps

module cm2a_lane (
  input  logic [2:0]          lane_idx,
  input  cm2a_pkg::lane_in_t  lane_in,
  output cm2a_pkg::word_t     word_nxt
);

  cm2a_pkg::word_t op_a [4];
  cm2a_pkg::word_t op_b [4];
  logic [3:0]      neg;
  cm2a_pkg::prod_t prod [4];
  cm2a_pkg::sum_t  term [4];
  cm2a_pkg::sum_t  sum_all;
  cm2a_pkg::sum_t  sum_rnd;
  cm2a_pkg::sum_t  sum_shr;
  cm2a_pkg::sum_t  sum_add;
  logic            is_imag;
  logic            is_diag;

  assign is_imag = lane_idx[0];
  assign is_diag = (lane_idx == cm2a_pkg::IDX_M00_RE) || (lane_idx == cm2a_pkg::IDX_M11_RE);

  // scale reuses product slot 0, the other slots carry zeros
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    neg = 4'b0000;
    if (lane_in.action == cm2a_pkg::ACT_SCALE) begin
      op_a[0] = lane_in.own_acc;
      op_b[0] = lane_in.scale;
    end else if (is_imag) begin
      op_a[0] = lane_in.a0r; op_b[0] = lane_in.x0i;
      op_a[1] = lane_in.a0i; op_b[1] = lane_in.x0r;
      op_a[2] = lane_in.a1r; op_b[2] = lane_in.x1i;
      op_a[3] = lane_in.a1i; op_b[3] = lane_in.x1r;
    end else begin
      op_a[0] = lane_in.a0r; op_b[0] = lane_in.x0r;
      op_a[1] = lane_in.a0i; op_b[1] = lane_in.x0i;
      op_a[2] = lane_in.a1r; op_b[2] = lane_in.x1r;
      op_a[3] = lane_in.a1i; op_b[3] = lane_in.x1i;
      neg     = 4'b1010;   // i*i terms subtract
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = op_a[i] * op_b[i];
      term[i] = neg[i] ? -cm2a_pkg::sum_t'(prod[i]) : cm2a_pkg::sum_t'(prod[i]);
    end
  end

  assign sum_all = term[0] + term[1] + term[2] + term[3];
  assign sum_rnd = sum_all + cm2a_pkg::HALF_S;     // round half up
  assign sum_shr = sum_rnd >>> cm2a_pkg::FRAC_BITS;
  assign sum_add = (lane_in.action == cm2a_pkg::ACT_SUB)
                 ? cm2a_pkg::sum_t'(lane_in.own_acc) - cm2a_pkg::sum_t'(lane_in.own_b)
                 : cm2a_pkg::sum_t'(lane_in.own_acc) + cm2a_pkg::sum_t'(lane_in.own_b);

  always_comb begin
    case (lane_in.action)
      cm2a_pkg::ACT_ZERO:  word_nxt = '0;
      cm2a_pkg::ACT_IDENT: word_nxt = is_diag ? cm2a_pkg::ONE_W : '0;
      cm2a_pkg::ACT_LOAD:  word_nxt = lane_in.own_b;
      cm2a_pkg::ACT_ADD:   word_nxt = cm2a_pkg::sat_word(sum_add);
      cm2a_pkg::ACT_SUB:   word_nxt = cm2a_pkg::sat_word(sum_add);
      cm2a_pkg::ACT_SCALE: word_nxt = cm2a_pkg::sat_word(sum_shr);
      cm2a_pkg::ACT_MUL:   word_nxt = cm2a_pkg::sat_word(sum_shr);
      default:             word_nxt = lane_in.own_acc;
    endcase
  end

endmodule

>>> hw/rtl/cm2a_outbuf.sv
// Merge stage: packs the lane words into a result item, output register plus skid entry.
`timescale 1ns / 1ps

module cm2a_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cm2a_pkg::word_t     word_in [cm2a_pkg::NUM_WORDS],
  input  logic                out_stall,
  output logic                out_valid,
  output cm2a_pkg::out_item_t out_data,
  output logic                full
);

  cm2a_pkg::out_item_t new_item;
  cm2a_pkg::out_item_t main_data_r, main_data_nxt;
  cm2a_pkg::out_item_t skid_data_r, skid_data_nxt;
  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  logic                drain;

  assign new_item = '{m00_re: word_in[0], m00_im: word_in[1],
                      m01_re: word_in[2], m01_im: word_in[3],
                      m10_re: word_in[4], m10_im: word_in[5],
                      m11_re: word_in[6], m11_im: word_in[7]};

  assign drain = main_valid_r & ~out_stall;

  // push never arrives while the skid entry is full
  always_comb begin
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (drain) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_valid_r & out_stall) begin
        skid_data_nxt  = new_item;
        skid_valid_nxt = 1'b1;
      end else begin
        main_data_nxt  = new_item;
        main_valid_nxt = 1'b1;
      end
    end else if (drain) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;
  assign full      = skid_valid_r;

endmodule

>>> hw/rtl/complex_2x2_matrix_accumulator_core.sv
// Top level of the complex 2x2 matrix accumulator: state register, eight lanes, output buffer.
`timescale 1ns / 1ps

// Holds one 2x2 complex matrix M of Q2.14 words and updates it with each input
// item: zero, identity, load B, add B, subtract B, scale by a real, or M = M*B.
// Every accepted item gives exactly one result item: M after the update.
// Input channel: in_valid / in_stall / in_data; an item is taken at a rising
// edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall / out_data, same rules, out_stall
// driven by the receiver.
// Result: written into the output register, or the skid entry, when its item is taken.
// Throughput: one item per cycle while in_stall is low; the eight lanes each compute one word of the
// next matrix combinationally (four 16x16 products summed, rounded, clamped),
// so back-to-back multiplies chain without gaps.
// Stall: one skid entry stands behind the output register, so one more item is
// taken while a result waits; in_stall then rises until the receiver drains.
// Reset (rst_n low, synchronous): matrix cleared to zero, both buffers empty.
module complex_2x2_matrix_accumulator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cm2a_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cm2a_pkg::out_item_t out_data
);

  cm2a_pkg::word_t acc_r   [cm2a_pkg::NUM_WORDS];
  cm2a_pkg::word_t acc_nxt [cm2a_pkg::NUM_WORDS];
  cm2a_pkg::word_t b_w     [cm2a_pkg::NUM_WORDS];
  logic            in_accept;
  logic            buf_full;

  assign in_stall  = buf_full;
  assign in_accept = in_valid & ~buf_full;

  // operand words in accumulator order: entry (r,c) real at 4r+2c, imag next
  assign b_w[0] = in_data.b00_re;
  assign b_w[1] = in_data.b00_im;
  assign b_w[2] = in_data.b01_re;
  assign b_w[3] = in_data.b01_im;
  assign b_w[4] = in_data.b10_re;
  assign b_w[5] = in_data.b10_im;
  assign b_w[6] = in_data.b11_re;
  assign b_w[7] = in_data.b11_im;

  // one lane per result word; each sees its row of M and its column of B
  for (genvar k = 0; k < cm2a_pkg::NUM_WORDS; k++) begin : g_lane
    localparam int R = k / 4;
    localparam int C = (k / 2) % 2;
    cm2a_pkg::lane_in_t lane_in;

    assign lane_in = '{action:  in_data.action,
                       a0r:     acc_r[4*R],
                       a0i:     acc_r[4*R+1],
                       a1r:     acc_r[4*R+2],
                       a1i:     acc_r[4*R+3],
                       x0r:     b_w[2*C],
                       x0i:     b_w[2*C+1],
                       x1r:     b_w[4+2*C],
                       x1i:     b_w[5+2*C],
                       own_acc: acc_r[k],
                       own_b:   b_w[k],
                       scale:   in_data.scale_factor};

    cm2a_lane u_lane (
      .lane_idx (3'(k)),
      .lane_in  (lane_in),
      .word_nxt (acc_nxt[k])
    );
  end

  // accumulator moves only when an item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cm2a_pkg::NUM_WORDS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (in_accept) begin
      for (int i = 0; i < cm2a_pkg::NUM_WORDS; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

  cm2a_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .word_in   (acc_nxt),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

endmodule

>>> hw/rtl/cm2a_checker.sv
// Port-level checks for the complex 2x2 accumulator, bound to the top level.
`timescale 1ns / 1ps

module cm2a_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cm2a_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input cm2a_pkg::out_item_t out_data
);

  localparam int B_LO = cm2a_pkg::WORD_BITS;
  localparam int B_HI = cm2a_pkg::WORD_BITS * (cm2a_pkg::NUM_WORDS + 1) - 1;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every taken item leaves a result on show next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after taken item");

  // input back-pressure only builds from a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without output stall");

  // zero action with an empty output shows an all-zero matrix
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && (in_data.action == cm2a_pkg::ACT_ZERO)
    |=> out_data == '0)
    else $error("zero action gave non-zero matrix");

  // load action with an empty output shows the operand matrix
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && (in_data.action == cm2a_pkg::ACT_LOAD)
    |=> out_data == $past(in_data[B_HI:B_LO]))
    else $error("load action gave wrong matrix");

endmodule

bind complex_2x2_matrix_accumulator_core cm2a_checker u_cm2a_checker (.*);

>>> test/tb_complex_2x2_matrix_accumulator_core.sv
// Self-checking testbench for the complex 2x2 matrix accumulator core.
`timescale 1ns / 1ps

module tb_complex_2x2_matrix_accumulator_core;

  // action 7 has no meaning: the matrix is held and shown again
  localparam logic [cm2a_pkg::ACT_BITS-1:0] ACT_HOLD = 3'd7;
  localparam int     IDLE_LIMIT  = 200;
  localparam int     MAX_REPORTS = 10;
  localparam longint W_MAX = (longint'(1) << (cm2a_pkg::WORD_BITS - 1)) - 1;
  localparam longint W_MIN = -(longint'(1) << (cm2a_pkg::WORD_BITS - 1));
  localparam longint HALF_LSB = longint'(1) << (cm2a_pkg::FRAC_BITS - 1);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cm2a_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cm2a_pkg::out_item_t out_data;

  // idling switches for the two sides
  bit feed_gaps = 1'b1;
  bit drain_stalls = 1'b1;

  longint              acc_m [cm2a_pkg::NUM_WORDS];
  cm2a_pkg::out_item_t pending_matrices [$];
  int                  field_errors = 0;
  int                  idle_cycles = 0;
  string               field_name [cm2a_pkg::NUM_WORDS] =
                         '{"m00_re", "m00_im", "m01_re", "m01_im",
                           "m10_re", "m10_im", "m11_re", "m11_im"};

  complex_2x2_matrix_accumulator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sx(input cm2a_pkg::word_t w);
    return longint'(w);
  endfunction

  function automatic longint clamp_w(input longint x);
    if (x > W_MAX) begin
      return W_MAX;
    end
    if (x < W_MIN) begin
      return W_MIN;
    end
    return x;
  endfunction

  // exact value rescaled by 2^-FRAC_BITS, half up, then saturated
  function automatic longint rescale(input longint x);
    return clamp_w((x + HALF_LSB) >>> cm2a_pkg::FRAC_BITS);
  endfunction

  // updates the held matrix for one item and returns it as the block shows it
  function automatic cm2a_pkg::out_item_t apply_action(input cm2a_pkg::in_item_t it);
    longint b [cm2a_pkg::NUM_WORDS];
    longint nx [cm2a_pkg::NUM_WORDS];
    longint s, a0r, a0i, a1r, a1i, x0r, x0i, x1r, x1i;
    logic [cm2a_pkg::NUM_WORDS*cm2a_pkg::WORD_BITS-1:0] flat;
    int r, c;
    b[0] = sx(it.b00_re); b[1] = sx(it.b00_im);
    b[2] = sx(it.b01_re); b[3] = sx(it.b01_im);
    b[4] = sx(it.b10_re); b[5] = sx(it.b10_im);
    b[6] = sx(it.b11_re); b[7] = sx(it.b11_im);
    s = sx(it.scale_factor);
    case (it.action)
      cm2a_pkg::ACT_ZERO: begin
        foreach (acc_m[i]) acc_m[i] = 0;
      end
      cm2a_pkg::ACT_IDENT: begin
        foreach (acc_m[i]) acc_m[i] = 0;
        acc_m[0] = clamp_w(longint'(1) << cm2a_pkg::FRAC_BITS);
        acc_m[6] = acc_m[0];
      end
      cm2a_pkg::ACT_LOAD: begin
        foreach (acc_m[i]) acc_m[i] = b[i];
      end
      cm2a_pkg::ACT_ADD: begin
        foreach (acc_m[i]) acc_m[i] = clamp_w(acc_m[i] + b[i]);
      end
      cm2a_pkg::ACT_SUB: begin
        foreach (acc_m[i]) acc_m[i] = clamp_w(acc_m[i] - b[i]);
      end
      cm2a_pkg::ACT_SCALE: begin
        foreach (acc_m[i]) acc_m[i] = rescale(acc_m[i] * s);
      end
      cm2a_pkg::ACT_MUL: begin
        for (r = 0; r < 2; r++) begin
          for (c = 0; c < 2; c++) begin
            a0r = acc_m[4*r];     a0i = acc_m[4*r+1];
            a1r = acc_m[4*r+2];   a1i = acc_m[4*r+3];
            x0r = b[2*c];         x0i = b[2*c+1];
            x1r = b[4+2*c];       x1i = b[5+2*c];
            nx[4*r+2*c]   = rescale(a0r*x0r - a0i*x0i + a1r*x1r - a1i*x1i);
            nx[4*r+2*c+1] = rescale(a0r*x0i + a0i*x0r + a1r*x1i + a1i*x1r);
          end
        end
        foreach (acc_m[i]) acc_m[i] = nx[i];
      end
      default: ;
    endcase
    for (int i = 0; i < cm2a_pkg::NUM_WORDS; i++) begin
      flat[(cm2a_pkg::NUM_WORDS-1-i)*cm2a_pkg::WORD_BITS +: cm2a_pkg::WORD_BITS] =
        acc_m[i][cm2a_pkg::WORD_BITS-1:0];
    end
    return cm2a_pkg::out_item_t'(flat);
  endfunction

  task automatic check_matrix(input cm2a_pkg::out_item_t got);
    logic [cm2a_pkg::NUM_WORDS*cm2a_pkg::WORD_BITS-1:0] want_f, got_f;
    cm2a_pkg::out_item_t want;
    got_f = got;
    if (pending_matrices.size() == 0) begin
      if (field_errors < MAX_REPORTS) begin
        $display("%0t: unexpected result %h", $realtime, got_f);
      end
      field_errors++;
    end else begin
      want = pending_matrices.pop_front();
      want_f = want;
      for (int i = 0; i < cm2a_pkg::NUM_WORDS; i++) begin
        if (want_f[(cm2a_pkg::NUM_WORDS-1-i)*cm2a_pkg::WORD_BITS +: cm2a_pkg::WORD_BITS] !==
            got_f[(cm2a_pkg::NUM_WORDS-1-i)*cm2a_pkg::WORD_BITS +: cm2a_pkg::WORD_BITS])
        begin
          if (field_errors < MAX_REPORTS) begin
            $display("%0t: %s expected %h got %h", $realtime, field_name[i],
                     want_f[(cm2a_pkg::NUM_WORDS-1-i)*cm2a_pkg::WORD_BITS +:
                            cm2a_pkg::WORD_BITS],
                     got_f[(cm2a_pkg::NUM_WORDS-1-i)*cm2a_pkg::WORD_BITS +:
                           cm2a_pkg::WORD_BITS]);
          end
          field_errors++;
        end
      end
    end
  endtask

  // results are checked before the item taken at the same edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_matrix(out_data);
      end
      if (in_valid && !in_stall) begin
        pending_matrices.push_back(apply_action(in_data));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: a random hold-off before each result, then take it
  initial begin : result_sink
    int pause;
    forever begin
      pause = drain_stalls ? $urandom_range(0, 3) : 0;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(input cm2a_pkg::in_item_t it);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic cm2a_pkg::word_t rand_fraction(input int lim);
    return cm2a_pkg::word_t'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic cm2a_pkg::word_t rand_word();
    cm2a_pkg::word_t w;
    case ($urandom_range(0, 3))
      0: w = cm2a_pkg::word_t'($urandom);
      1: w = rand_fraction(16384);
      2: w = rand_fraction(1024);
      default: begin
        case ($urandom_range(0, 4))
          0: w = cm2a_pkg::WORD_MIN_W;
          1: w = cm2a_pkg::WORD_MAX_W;
          2: w = '0;
          3: w = '1;
          default: w = cm2a_pkg::ONE_W;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic cm2a_pkg::in_item_t rand_item(input logic [cm2a_pkg::ACT_BITS-1:0] act);
    cm2a_pkg::in_item_t it;
    it.action = act;
    it.b00_re = rand_word(); it.b00_im = rand_word();
    it.b01_re = rand_word(); it.b01_im = rand_word();
    it.b10_re = rand_word(); it.b10_im = rand_word();
    it.b11_re = rand_word(); it.b11_im = rand_word();
    it.scale_factor = rand_word();
    return it;
  endfunction

  // operand with every entry the same word
  function automatic cm2a_pkg::in_item_t fill_item(input logic [cm2a_pkg::ACT_BITS-1:0] act,
                                                   input cm2a_pkg::word_t w,
                                                   input cm2a_pkg::word_t s);
    cm2a_pkg::in_item_t it;
    it = {act, {cm2a_pkg::NUM_WORDS{w}}, s};
    return it;
  endfunction

  function automatic logic [cm2a_pkg::ACT_BITS-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return cm2a_pkg::ACT_ZERO;
    if (r < 8)  return cm2a_pkg::ACT_IDENT;
    if (r < 22) return cm2a_pkg::ACT_LOAD;
    if (r < 40) return cm2a_pkg::ACT_ADD;
    if (r < 55) return cm2a_pkg::ACT_SUB;
    if (r < 70) return cm2a_pkg::ACT_SCALE;
    if (r < 97) return cm2a_pkg::ACT_MUL;
    return ACT_HOLD;
  endfunction

  // corners: saturation both ways, half-LSB rounding, ignored operands, action 7
  task automatic test_directed_corners();
    send_item(rand_item(cm2a_pkg::ACT_IDENT));
    send_item(fill_item(cm2a_pkg::ACT_MUL, cm2a_pkg::WORD_MIN_W, rand_word()));
    send_item(fill_item(cm2a_pkg::ACT_MUL, cm2a_pkg::WORD_MIN_W, rand_word()));
    send_item(rand_item(cm2a_pkg::ACT_ZERO));
    send_item(fill_item(cm2a_pkg::ACT_LOAD, cm2a_pkg::WORD_MAX_W, cm2a_pkg::WORD_MIN_W));
    send_item(fill_item(cm2a_pkg::ACT_ADD, cm2a_pkg::WORD_MAX_W, cm2a_pkg::WORD_MAX_W));
    send_item(fill_item(cm2a_pkg::ACT_SUB, cm2a_pkg::WORD_MIN_W, '0));
    send_item(fill_item(cm2a_pkg::ACT_SCALE, '1, cm2a_pkg::WORD_MAX_W));
    send_item(fill_item(cm2a_pkg::ACT_LOAD, cm2a_pkg::WORD_MIN_W, cm2a_pkg::WORD_MAX_W));
    send_item(fill_item(cm2a_pkg::ACT_SUB, cm2a_pkg::WORD_MAX_W, '1));
    send_item(fill_item(cm2a_pkg::ACT_ADD, cm2a_pkg::WORD_MIN_W, cm2a_pkg::ONE_W));
    send_item(fill_item(cm2a_pkg::ACT_SCALE, cm2a_pkg::WORD_MAX_W, cm2a_pkg::WORD_MIN_W));
    // one LSB times 0.5 rounds up, minus one LSB times 0.5 rounds to zero
    send_item(fill_item(cm2a_pkg::ACT_LOAD, cm2a_pkg::word_t'(1), '0));
    send_item(fill_item(cm2a_pkg::ACT_SCALE, cm2a_pkg::WORD_MIN_W, cm2a_pkg::word_t'(8192)));
    send_item(fill_item(cm2a_pkg::ACT_LOAD, '1, cm2a_pkg::WORD_MAX_W));
    send_item(fill_item(cm2a_pkg::ACT_SCALE, '0, cm2a_pkg::word_t'(8192)));
    send_item(fill_item(cm2a_pkg::ACT_LOAD, cm2a_pkg::word_t'(3), '0));
    send_item(fill_item(cm2a_pkg::ACT_SCALE, '1, cm2a_pkg::word_t'(8192)));
    send_item(rand_item(ACT_HOLD));
    send_item(fill_item(cm2a_pkg::ACT_SCALE, cm2a_pkg::WORD_MAX_W, '0));
    send_item(rand_item(cm2a_pkg::ACT_IDENT));
    send_item(fill_item(cm2a_pkg::ACT_MUL, cm2a_pkg::WORD_MAX_W, rand_word()));
    send_item(rand_item(cm2a_pkg::ACT_LOAD));
    send_item(rand_item(cm2a_pkg::ACT_MUL));
    wait_results_drained();
  endtask

  task automatic test_random_actions(input int n);
    repeat (n) send_item(rand_item(pick_action()));
  endtask

  // long product chains at full rate, reloaded now and then
  task automatic test_chained_multiply(input int n);
    cm2a_pkg::in_item_t it;
    feed_gaps = 1'b0;
    drain_stalls = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 12 == 0) begin
        it = rand_item(($urandom_range(0, 1) != 0) ? cm2a_pkg::ACT_IDENT
                                                    : cm2a_pkg::ACT_LOAD);
      end else begin
        it = rand_item(cm2a_pkg::ACT_MUL);
        it.b00_re = rand_fraction(11585); it.b00_im = rand_fraction(11585);
        it.b01_re = rand_fraction(11585); it.b01_im = rand_fraction(11585);
        it.b10_re = rand_fraction(11585); it.b10_im = rand_fraction(11585);
        it.b11_re = rand_fraction(11585); it.b11_im = rand_fraction(11585);
      end
      send_item(it);
    end
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
  endtask

  // bursts with the sender held off until every result is out
  task automatic test_pause_until_drained(input int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) send_item(rand_item(pick_action()));
      left -= burst;
      wait_results_drained();
    end
  endtask

  // full-rate sender against a stalling receiver: skid entry fills and empties
  task automatic test_output_backpressure(input int n);
    feed_gaps = 1'b0;
    test_random_actions(n);
    feed_gaps = 1'b1;
  endtask

  task automatic test_bursty_input(input int n);
    drain_stalls = 1'b0;
    test_random_actions(n);
    drain_stalls = 1'b1;
  endtask

  initial begin
    foreach (acc_m[i]) acc_m[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_random_actions(1000);
    test_chained_multiply(300);
    test_pause_until_drained(120);
    test_output_backpressure(250);
    test_bursty_input(150);
    wait_results_drained();
    if (pending_matrices.size() != 0) begin
      $display("%0d results never arrived", pending_matrices.size());
    end
    if (field_errors == 0 && pending_matrices.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
